@@ sv/mrtu_pkg.sv @@
// shared types and constants of the modbus rtu frame receiver
package mrtu_pkg;

  // input item codes
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_POP     = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  // frame status codes
  localparam logic [2:0] STATUS_NONE       = 3'd0;
  localparam logic [2:0] STATUS_ACCEPTED   = 3'd1;
  localparam logic [2:0] STATUS_BAD_ADDR   = 3'd2;
  localparam logic [2:0] STATUS_BAD_FUNC   = 3'd3;
  localparam logic [2:0] STATUS_BAD_LENGTH = 3'd4;
  localparam logic [2:0] STATUS_QUEUE_FULL = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_FUNCTION = 1'b1;

  // register reset values
  localparam logic [7:0] SLAVE_ADDR_RST        = 8'h00;
  localparam logic [7:0] ACCEPTED_FUNCTION_RST = 8'h04;

  // frame geometry
  localparam int unsigned FRAME_LEN   = 8;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned FCOUNT_W    = 4;
  localparam logic [FCOUNT_W-1:0] FCOUNT_FULL = 4'd8;
  localparam logic [FCOUNT_W-1:0] FCOUNT_SAT  = 4'd9;
  localparam logic [FCOUNT_W-1:0] FCOUNT_CRC  = 4'd6;

  // crc-16/modbus, reflected polynomial
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // queue entry: eight frame bytes and the crc check flag
  localparam int unsigned ENTRY_W = 65;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_FINISH
  } ctrl_state_t;

  // datapath operation started on an input transfer
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_TIMEOUT,
    OP_POP,
    OP_IGNORE
  } op_t;

  // commands from controller to datapath
  typedef struct packed {
    op_t  op;
    logic crc_shift;
    logic load_out;
  } mrtu_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic crc_needed;
    logic bit_last;
    logic out_free;
  } mrtu_stat_t;

endpackage

@@ sv/modbus_rtu_frame_receiver_top.sv @@
// Modbus RTU frame receiver: one result per input item. A received byte among the first
// six of a frame passes through the transfer, the one-bit-per-cycle CRC-16/MODBUS update
// over its eight bits and the result load; any other byte, a frame gap timeout and a pop
// go straight to the result load, fed for a pop by the registered command queue RAM read.
// A result sits in an output register, so the next item is taken while it waits; a
// result is loaded only once the previous one has been transferred. Configuration
// writes are taken at any time but are meant for an idle block.
module modbus_rtu_frame_receiver_top #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               cmd_valid,
  output logic [7:0]                         cmd_address,
  output logic [7:0]                         cmd_function,
  output logic [31:0]                        cmd_payload,
  output logic [15:0]                        cmd_crc,
  output logic                               crc_ok,
  output logic [3:0]                         pending_count,
  output logic [2:0]                         frame_status
);
  import mrtu_pkg::*;

  mrtu_cmd_t  cmd;
  mrtu_stat_t stat;

  // controller
  mrtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  mrtu_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd_valid     (cmd_valid),
    .cmd_address   (cmd_address),
    .cmd_function  (cmd_function),
    .cmd_payload   (cmd_payload),
    .cmd_crc       (cmd_crc),
    .crc_ok        (crc_ok),
    .pending_count (pending_count),
    .frame_status  (frame_status)
  );

endmodule

@@ sv/mrtu_ram.sv @@
// generic single write port ram with registered read
module mrtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/mrtu_datapath.sv @@
// frame buffer, bit-serial crc, command queue and result register
module mrtu_datapath #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mrtu_pkg::mrtu_cmd_t                cmd,
  output mrtu_pkg::mrtu_stat_t               stat,
  input  logic                               cfg_we,
  input  logic [mrtu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               cmd_valid,
  output logic [7:0]                         cmd_address,
  output logic [7:0]                         cmd_function,
  output logic [31:0]                        cmd_payload,
  output logic [15:0]                        cmd_crc,
  output logic                               crc_ok,
  output logic [3:0]                         pending_count,
  output logic [2:0]                         frame_status
);
  import mrtu_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  logic [7:0]          slave_addr;
  logic [7:0]          accepted_function;
  logic [7:0]          frame_bytes [FRAME_LEN];
  logic [POS_W-1:0]    frame_write_pos;
  logic [FCOUNT_W-1:0] frame_byte_count;
  logic [15:0]         running_crc;
  logic [2:0]          bit_cnt;
  logic [AW-1:0]       queue_head;
  logic [AW-1:0]       queue_tail;
  logic [CW-1:0]       queue_count;
  logic                res_valid;
  logic [2:0]          res_status;
  logic [2:0]          timeout_status;
  logic [ENTRY_W-1:0]  entry_wdata;
  logic [ENTRY_W-1:0]  entry_rdata;
  logic                q_write;
  logic                q_read;
  logic [CW+3:0]       count_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr        <= SLAVE_ADDR_RST;
      accepted_function <= ACCEPTED_FUNCTION_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLAVE_ADDR:        slave_addr        <= cfg_data;
        REG_ACCEPTED_FUNCTION: accepted_function <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame check on timeout: length, address, function, then queue space
  always_comb begin
    if (frame_byte_count != FCOUNT_FULL) begin
      timeout_status = STATUS_BAD_LENGTH;
    end else if (frame_bytes[0] != slave_addr) begin
      timeout_status = STATUS_BAD_ADDR;
    end else if (frame_bytes[1] != accepted_function) begin
      timeout_status = STATUS_BAD_FUNC;
    end else if (queue_count >= FULL_COUNT) begin
      timeout_status = STATUS_QUEUE_FULL;
    end else begin
      timeout_status = STATUS_ACCEPTED;
    end
  end

  // queue entry and ram strobes
  assign entry_wdata = {frame_bytes[0], frame_bytes[1], frame_bytes[2], frame_bytes[3],
                        frame_bytes[4], frame_bytes[5], frame_bytes[6], frame_bytes[7],
                        running_crc == {frame_bytes[7], frame_bytes[6]}};
  assign q_write = (cmd.op == OP_TIMEOUT) && (timeout_status == STATUS_ACCEPTED);
  assign q_read  = (cmd.op == OP_POP) && (queue_count != '0);

  mrtu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_write),
    .waddr (queue_head),
    .wdata (entry_wdata),
    .re    (q_read),
    .raddr (queue_tail),
    .rdata (entry_rdata)
  );

  // frame buffer bytes
  always_ff @(posedge clk) begin
    if (cmd.op == OP_BYTE) begin
      frame_bytes[frame_write_pos] <= rx_byte;
    end
  end

  // frame position, count and bit-serial crc
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_write_pos  <= '0;
      frame_byte_count <= '0;
      running_crc      <= CRC_SEED;
      bit_cnt          <= '0;
    end else if (cmd.op == OP_BYTE) begin
      frame_write_pos <= frame_write_pos + 1'b1;
      if (frame_byte_count < FCOUNT_SAT) begin
        frame_byte_count <= frame_byte_count + 1'b1;
      end
      if (frame_byte_count < FCOUNT_CRC) begin
        running_crc <= running_crc ^ {8'h00, rx_byte};
      end
      bit_cnt <= '0;
    end else if (cmd.op == OP_TIMEOUT) begin
      frame_write_pos  <= '0;
      frame_byte_count <= '0;
      running_crc      <= CRC_SEED;
    end else if (cmd.crc_shift) begin
      running_crc <= running_crc[0] ? ((running_crc >> 1) ^ CRC_POLY) : (running_crc >> 1);
      bit_cnt     <= bit_cnt + 1'b1;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
    end else if (q_write) begin
      queue_head  <= (queue_head == LAST_ADDR) ? '0 : queue_head + 1'b1;
      queue_count <= queue_count + 1'b1;
    end else if (q_read) begin
      queue_tail  <= (queue_tail == LAST_ADDR) ? '0 : queue_tail + 1'b1;
      queue_count <= queue_count - 1'b1;
    end
  end

  // per-item result kind, captured at the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      res_status <= STATUS_NONE;
    end else if (cmd.op != OP_NONE) begin
      res_valid  <= q_read;
      res_status <= (cmd.op == OP_TIMEOUT) ? timeout_status : STATUS_NONE;
    end
  end

  // output register
  assign count_ext = (CW + 4)'(queue_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cmd_valid     <= res_valid;
      cmd_address   <= res_valid ? entry_rdata[64:57] : 8'h00;
      cmd_function  <= res_valid ? entry_rdata[56:49] : 8'h00;
      cmd_payload   <= res_valid ? entry_rdata[48:17] : 32'h0;
      cmd_crc       <= res_valid ? {entry_rdata[8:1], entry_rdata[16:9]} : 16'h0;
      crc_ok        <= res_valid ? entry_rdata[0] : 1'b0;
      pending_count <= count_ext[3:0];
      frame_status  <= res_status;
    end
  end

  // status to controller
  assign stat.crc_needed = frame_byte_count < FCOUNT_CRC;
  assign stat.bit_last   = bit_cnt == 3'd7;
  assign stat.out_free   = !out_valid || !out_stall;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= FULL_COUNT)
    else $error("queue count above depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    q_write |=> queue_count == $past(queue_count) + 1'b1)
    else $error("accepted frame did not enter queue");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_POP && queue_count == '0) |=> $stable(queue_tail) && !res_valid)
    else $error("pop on empty queue changed state");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a waiting result");

endmodule

@@ sv/mrtu_ctrl.sv @@
// controller state machine of the frame receiver
module mrtu_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  mrtu_pkg::mrtu_stat_t  stat,
  output mrtu_pkg::mrtu_cmd_t   cmd
);
  import mrtu_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (func == FUNC_BYTE && stat.crc_needed) begin
            state_next = ST_CRC;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_CRC: begin
        if (stat.bit_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    cmd.op        = OP_NONE;
    cmd.crc_shift = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (func)
            FUNC_BYTE:    cmd.op = OP_BYTE;
            FUNC_TIMEOUT: cmd.op = OP_TIMEOUT;
            FUNC_POP:     cmd.op = OP_POP;
            default:      cmd.op = OP_IGNORE;
          endcase
        end
      end
      ST_CRC: begin
        cmd.crc_shift = 1'b1;
      end
      ST_FINISH: begin
        cmd.load_out = stat.out_free;
      end
      default: ;
    endcase
  end

  // checks
  a_crc_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC && !stat.bit_last) |=> state == ST_CRC)
    else $error("crc loop left early");

  a_op_only_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |=> state != ST_IDLE)
    else $error("transfer without work");

endmodule

@@ dv/tb_modbus_rtu_frame_receiver_top.sv @@
// self-checking testbench of the modbus rtu frame receiver with command queue
module tb_modbus_rtu_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtu_pkg::*;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned N_SETTINGS = 6;
  localparam int unsigned ITEMS_PER_SETTING = 180;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct {
    logic [1:0] f;
    logic [7:0] b;
  } rx_item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [7:0]  cmd_address;
    logic [7:0]  cmd_function;
    logic [31:0] cmd_payload;
    logic [15:0] cmd_crc;
    logic        crc_ok;
    logic [3:0]  pending_count;
    logic [2:0]  frame_status;
  } rx_result_t;

  typedef struct {
    logic [63:0] word;
    logic        crc_good;
  } cmd_entry_t;

  // dut connections, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SLAVE_ADDR;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        cmd_valid;
  logic [7:0]  cmd_address;
  logic [7:0]  cmd_function;
  logic [31:0] cmd_payload;
  logic [15:0] cmd_crc;
  logic        crc_ok;
  logic [3:0]  pending_count;
  logic [2:0]  frame_status;

  // predictor state
  logic [7:0]  dev_addr = SLAVE_ADDR_RST;
  logic [7:0]  accept_fn = ACCEPTED_FUNCTION_RST;
  logic [7:0]  frm_buf [FRAME_LEN];
  logic [2:0]  frm_pos = '0;
  logic [3:0]  frm_cnt = '0;
  logic [15:0] frm_crc = CRC_SEED;
  cmd_entry_t  cmd_store [$];

  // stimulus and expectations
  rx_item_t    send_q [$];
  rx_result_t  due_results [$];
  bit          gap_on = 1'b0;
  bit          stall_on = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cmds_popped = 0;
  int unsigned status_seen [6] = '{default: 0};
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  modbus_rtu_frame_receiver_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd_valid    (cmd_valid),
    .cmd_address  (cmd_address),
    .cmd_function (cmd_function),
    .cmd_payload  (cmd_payload),
    .cmd_crc      (cmd_crc),
    .crc_ok       (crc_ok),
    .pending_count(pending_count),
    .frame_status (frame_status)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // one byte of the reflected crc-16/modbus update
  function automatic logic [15:0] crc16_feed(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // advance the receiver state by one item and return its result
  function automatic rx_result_t rx_item_outcome(logic [1:0] f, logic [7:0] b);
    rx_result_t r;
    cmd_entry_t e;
    logic [15:0] sent;
    r = '0;
    case (f)
      FUNC_BYTE: begin
        frm_buf[frm_pos] = b;
        if (frm_cnt < FCOUNT_CRC) frm_crc = crc16_feed(frm_crc, b);
        frm_pos = frm_pos + 3'd1;
        if (frm_cnt < FCOUNT_SAT) frm_cnt = frm_cnt + 4'd1;
      end
      FUNC_TIMEOUT: begin
        if (frm_cnt != FCOUNT_FULL) begin
          r.frame_status = STATUS_BAD_LENGTH;
        end else if (frm_buf[0] != dev_addr) begin
          r.frame_status = STATUS_BAD_ADDR;
        end else if (frm_buf[1] != accept_fn) begin
          r.frame_status = STATUS_BAD_FUNC;
        end else if (cmd_store.size() >= QDEPTH) begin
          r.frame_status = STATUS_QUEUE_FULL;
        end else begin
          e.word = {frm_buf[0], frm_buf[1], frm_buf[2], frm_buf[3],
                    frm_buf[4], frm_buf[5], frm_buf[6], frm_buf[7]};
          sent = {frm_buf[7], frm_buf[6]};
          e.crc_good = (frm_crc == sent);
          cmd_store.push_back(e);
          r.frame_status = STATUS_ACCEPTED;
        end
        status_seen[r.frame_status]++;
        frm_pos = '0;
        frm_cnt = '0;
        frm_crc = CRC_SEED;
      end
      FUNC_POP: begin
        if (cmd_store.size() > 0) begin
          e = cmd_store.pop_front();
          r.cmd_valid = 1'b1;
          r.cmd_address = e.word[63:56];
          r.cmd_function = e.word[55:48];
          r.cmd_payload = e.word[47:16];
          r.cmd_crc = {e.word[7:0], e.word[15:8]};
          r.crc_ok = e.crc_good;
          cmds_popped++;
        end
      end
      default: ;
    endcase
    r.pending_count = 4'(cmd_store.size());
    return r;
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int unsigned pick_idle(bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom());
  endfunction

  task automatic push_item(logic [1:0] f, logic [7:0] b);
    rx_item_t it;
    it.f = f;
    it.b = b;
    send_q.push_back(it);
    if (f != FUNC_UNUSED) items_queued++;
  endtask

  // eight frame bytes and the closing gap, crc right or random
  task automatic push_frame(logic [7:0] a, logic [7:0] fn, bit good_crc);
    logic [7:0] fb [FRAME_LEN];
    logic [15:0] c;
    fb[0] = a;
    fb[1] = fn;
    c = crc16_feed(crc16_feed(CRC_SEED, a), fn);
    for (int i = 2; i < 6; i++) begin
      fb[i] = pick_byte();
      c = crc16_feed(c, fb[i]);
    end
    fb[6] = good_crc ? c[7:0] : 8'($urandom());
    fb[7] = good_crc ? c[15:8] : 8'($urandom());
    for (int i = 0; i < FRAME_LEN; i++) push_item(FUNC_BYTE, fb[i]);
    push_item(FUNC_TIMEOUT, 8'($urandom()));
  endtask

  // wait until the sender is empty and every result has come back
  task automatic drain_results();
    while (send_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SLAVE_ADDR) dev_addr = value;
    else accept_fn = value;
    @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // input driver: one transfer per accepted item, prediction on acceptance
  always @(posedge clk) begin
    rx_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(rx_item_outcome(func, rx_byte));
        if (func != FUNC_UNUSED) items_sent++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (send_q.size() != 0) begin
        nxt = send_q.pop_front();
        in_valid <= 1'b1;
        func <= nxt.f;
        rx_byte <= nxt.b;
        gap_left = pick_idle(gap_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    rx_result_t want;
    int unsigned n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("cmd_valid", 32'(want.cmd_valid), 32'(cmd_valid));
          check_field("cmd_address", 32'(want.cmd_address), 32'(cmd_address));
          check_field("cmd_function", 32'(want.cmd_function), 32'(cmd_function));
          check_field("cmd_payload", want.cmd_payload, cmd_payload);
          check_field("cmd_crc", 32'(want.cmd_crc), 32'(cmd_crc));
          check_field("crc_ok", 32'(want.crc_ok), 32'(crc_ok));
          check_field("pending_count", 32'(want.pending_count), 32'(pending_count));
          check_field("frame_status", 32'(want.frame_status), 32'(frame_status));
          results_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        n = pick_idle(stall_on);
        out_stall <= (n != 0);
        stall_left = (n != 0) ? n - 1 : 0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // reset, directed items, then random phases over several register settings
  initial begin
    logic [7:0] set_addr [N_SETTINGS];
    logic [7:0] set_fn [N_SETTINGS];
    int unsigned pop_pct [N_SETTINGS];
    bit set_gaps [N_SETTINGS];
    bit set_stalls [N_SETTINGS];
    int unsigned goal;
    int unsigned roll;
    int unsigned len;
    logic [7:0] a;
    logic [7:0] fn;
    bit drained;

    set_addr = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    set_fn = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
    pop_pct = '{25, 30, 3, 25, 45, 20};
    set_gaps = '{1, 1, 0, 1, 1, 1};
    set_stalls = '{1, 0, 1, 1, 0, 1};
    set_addr[4] = 8'($urandom());
    set_fn[4] = 8'($urandom());
    set_addr[5] = 8'($urandom());
    set_fn[5] = 8'($urandom());
    drained = 1'b0;
    for (int i = 0; i < FRAME_LEN; i++) frm_buf[i] = 8'h00;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty gap, empty pop, unused code, good frame, short and long frames
    push_item(FUNC_TIMEOUT, 8'h00);
    push_item(FUNC_POP, 8'hFF);
    push_item(FUNC_UNUSED, 8'hFF);
    push_frame(SLAVE_ADDR_RST, ACCEPTED_FUNCTION_RST, 1'b1);
    push_item(FUNC_BYTE, 8'h00);
    push_item(FUNC_BYTE, 8'h04);
    push_item(FUNC_TIMEOUT, 8'hFF);
    push_item(FUNC_POP, 8'h00);
    push_item(FUNC_POP, 8'h00);
    for (int i = 0; i < 9; i++) push_item(FUNC_BYTE, (i % 2 == 0) ? 8'h00 : 8'hFF);
    push_item(FUNC_TIMEOUT, 8'h00);
    drain_results();

    for (int p = 0; p < N_SETTINGS; p++) begin
      write_reg(REG_SLAVE_ADDR, set_addr[p]);
      write_reg(REG_ACCEPTED_FUNCTION, set_fn[p]);
      gap_on = set_gaps[p];
      stall_on = set_stalls[p];
      goal = items_queued + ITEMS_PER_SETTING;
      while (items_queued < goal) begin
        roll = $urandom_range(0, 99);
        if (roll < pop_pct[p]) begin
          push_item(FUNC_POP, 8'($urandom()));
        end else if (roll < pop_pct[p] + 3) begin
          push_item(FUNC_UNUSED, 8'($urandom()));
        end else if (roll < pop_pct[p] + 15) begin
          // broken frame: any length, gap usually closes it
          len = $urandom_range(0, 11);
          for (int i = 0; i < len; i++) push_item(FUNC_BYTE, pick_byte());
          if ($urandom_range(0, 4) != 0) push_item(FUNC_TIMEOUT, 8'($urandom()));
        end else begin
          a = ($urandom_range(0, 9) != 0) ? dev_addr : 8'($urandom());
          fn = ($urandom_range(0, 9) != 0) ? accept_fn : 8'($urandom());
          push_frame(a, fn, $urandom_range(0, 4) != 0);
        end
        // hold the sender once until the block has answered everything
        if (p == 3 && !drained && items_queued >= goal - ITEMS_PER_SETTING / 2) begin
          drained = 1'b1;
          drain_results();
        end
      end
      drain_results();
    end

    $display("covered %0d items over %0d register settings, %0d results checked",
             items_sent, N_SETTINGS + 1, results_checked);
    $display("frames: %0d accepted, %0d wrong address, %0d wrong function",
             status_seen[STATUS_ACCEPTED], status_seen[STATUS_BAD_ADDR],
             status_seen[STATUS_BAD_FUNC]);
    $display("frames: %0d bad length, %0d queue full, %0d popped",
             status_seen[STATUS_BAD_LENGTH], status_seen[STATUS_QUEUE_FULL], cmds_popped);
    if (errors == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mrtu_pkg.sv
sv/mrtu_ram.sv
sv/mrtu_datapath.sv
sv/mrtu_ctrl.sv
sv/modbus_rtu_frame_receiver_top.sv
dv/tb_modbus_rtu_frame_receiver_top.sv
